[rtl/psqrl_pkg.sv]
// ----------------------------------------------------------------------------
// psqrl_pkg
// Shared types and constants for the per-source query rate limiter.
// ----------------------------------------------------------------------------
package psqrl_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_PER_SOURCE_RATE = 3'd0;
  localparam logic [2:0] REG_WINDOW_SECONDS  = 3'd1;
  localparam logic [2:0] REG_TRACKED_LIMIT   = 3'd2;
  localparam logic [2:0] REG_PRUNE_QUOTA     = 3'd3;
  localparam logic [2:0] REG_GLOBAL_RATE     = 3'd4;

  // reset values of the registers
  localparam logic [15:0] RST_PER_SOURCE_RATE = 16'd10;
  localparam logic [15:0] RST_WINDOW_SECONDS  = 16'd30;
  localparam logic [11:0] RST_TRACKED_LIMIT   = 12'd4095;
  localparam logic [12:0] RST_PRUNE_QUOTA     = 13'd10;
  localparam logic [15:0] RST_GLOBAL_RATE     = 16'd500;

  localparam logic [12:0] COUNT_MAX = 13'h1FFF;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LATCH,
    DP_CLR_STEP,
    DP_READ_CUR,
    DP_SKIP,
    DP_DEL,
    DP_OVERLOAD,
    DP_SCAN_START,
    DP_SCAN_STEP,
    DP_MARK_FOUND,
    DP_READ_SLOT,
    DP_MOVE_UNLINK,
    DP_APPEND,
    DP_HIT,
    DP_GLOBAL,
    DP_INSERT,
    DP_OUT_LOAD
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRUNE_RD,
    ST_PRUNE_EVAL,
    ST_OVL,
    ST_OVL_CLEAR,
    ST_SCAN,
    ST_FOUND_RD,
    ST_FOUND_EVAL,
    ST_MOVE_APPEND,
    ST_GLOBAL,
    ST_INSERT,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic occ_zero;
    logic over_limit;
    logic room;
    logic rd_valid;
    logic is_src;
    logic is_last;
    logic young;
    logic stale;
    logic stop_after_del;
    logic scan_hit;
    logic scan_end;
    logic allowed;
    logic found;
    logic clr_last;
    logic out_busy;
  } dp_status_t;

endpackage

[rtl/psqrl_ctrl.sv]
// ----------------------------------------------------------------------------
// psqrl_ctrl
// Sequencer: walks one request through prune, overload, lookup, checks, insert.
// ----------------------------------------------------------------------------
module psqrl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  psqrl_pkg::dp_status_t st,
  output psqrl_pkg::dp_op_t     op
);

  psqrl_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psqrl_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = psqrl_pkg::DP_NOP;
    in_ready   = 1'b0;
    unique case (state)
      psqrl_pkg::ST_CLEAR: begin
        op = psqrl_pkg::DP_CLR_STEP;
        if (st.clr_last) state_next = psqrl_pkg::ST_IDLE;
      end
      psqrl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = psqrl_pkg::DP_LATCH;
          state_next = st.occ_zero ? psqrl_pkg::ST_OVL : psqrl_pkg::ST_PRUNE_RD;
        end
      end
      psqrl_pkg::ST_PRUNE_RD: begin
        op         = psqrl_pkg::DP_READ_CUR;
        state_next = psqrl_pkg::ST_PRUNE_EVAL;
      end
      psqrl_pkg::ST_PRUNE_EVAL: begin
        if (!st.rd_valid) begin
          state_next = psqrl_pkg::ST_OVL;
        end else if (st.is_src) begin
          if (st.is_last) begin
            state_next = psqrl_pkg::ST_OVL;
          end else begin
            op         = psqrl_pkg::DP_SKIP;
            state_next = psqrl_pkg::ST_PRUNE_RD;
          end
        end else if (st.young) begin
          state_next = psqrl_pkg::ST_OVL;
        end else begin
          op         = psqrl_pkg::DP_DEL;
          state_next = (st.stop_after_del || st.is_last) ? psqrl_pkg::ST_OVL
                                                          : psqrl_pkg::ST_PRUNE_RD;
        end
      end
      psqrl_pkg::ST_OVL: begin
        if (st.over_limit) begin
          op         = psqrl_pkg::DP_OVERLOAD;
          state_next = psqrl_pkg::ST_OVL_CLEAR;
        end else if (st.occ_zero) begin
          state_next = psqrl_pkg::ST_GLOBAL;
        end else begin
          op         = psqrl_pkg::DP_SCAN_START;
          state_next = psqrl_pkg::ST_SCAN;
        end
      end
      psqrl_pkg::ST_OVL_CLEAR: begin
        op = psqrl_pkg::DP_CLR_STEP;
        if (st.clr_last) state_next = psqrl_pkg::ST_GLOBAL;
      end
      psqrl_pkg::ST_SCAN: begin
        if (st.scan_hit) begin
          op         = psqrl_pkg::DP_MARK_FOUND;
          state_next = psqrl_pkg::ST_FOUND_RD;
        end else if (st.scan_end) begin
          state_next = psqrl_pkg::ST_GLOBAL;
        end else begin
          op = psqrl_pkg::DP_SCAN_STEP;
        end
      end
      psqrl_pkg::ST_FOUND_RD: begin
        op         = psqrl_pkg::DP_READ_SLOT;
        state_next = psqrl_pkg::ST_FOUND_EVAL;
      end
      psqrl_pkg::ST_FOUND_EVAL: begin
        if (st.stale) begin
          op         = psqrl_pkg::DP_MOVE_UNLINK;
          state_next = psqrl_pkg::ST_MOVE_APPEND;
        end else begin
          op         = psqrl_pkg::DP_HIT;
          state_next = psqrl_pkg::ST_GLOBAL;
        end
      end
      psqrl_pkg::ST_MOVE_APPEND: begin
        op         = psqrl_pkg::DP_APPEND;
        state_next = psqrl_pkg::ST_GLOBAL;
      end
      psqrl_pkg::ST_GLOBAL: begin
        if (st.allowed) op = psqrl_pkg::DP_GLOBAL;
        state_next = psqrl_pkg::ST_INSERT;
      end
      psqrl_pkg::ST_INSERT: begin
        if (st.allowed && !st.found && st.room) op = psqrl_pkg::DP_INSERT;
        state_next = psqrl_pkg::ST_DONE;
      end
      psqrl_pkg::ST_DONE: begin
        if (!st.out_busy) begin
          op         = psqrl_pkg::DP_OUT_LOAD;
          state_next = psqrl_pkg::ST_IDLE;
        end
      end
      default: state_next = psqrl_pkg::ST_CLEAR;
    endcase
  end

endmodule

[rtl/psqrl_dp.sv]
// ----------------------------------------------------------------------------
// psqrl_dp
// Datapath: source table memories, age list, free-slot stack, counters, output.
// ----------------------------------------------------------------------------
module psqrl_dp #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  psqrl_pkg::dp_op_t     op,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic [31:0]           source_addr,
  input  logic [31:0]           now_seconds,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  allowed,
  output logic                  overload_reset,
  output logic [12:0]           tracked_count,
  output psqrl_pkg::dp_status_t st
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W = ((OCC_W > 13) ? OCC_W : 13) + 1;

  // configuration
  logic [15:0] ps_rate, win_sec, g_rate;
  logic [11:0] trk_limit;
  logic [12:0] quota;
  logic [31:0] ps_lim, g_lim;
  logic [33:0] armed_raw;
  logic [16:0] g_p1, w_p1;

  // memories
  logic [31:0]      addr_mem  [TABLE_DEPTH];
  logic [31:0]      stamp_mem [TABLE_DEPTH];
  logic [31:0]      hits_mem  [TABLE_DEPTH];
  logic             valid_mem [TABLE_DEPTH];
  logic [IDX_W-1:0] older_mem [TABLE_DEPTH];
  logic [IDX_W-1:0] newer_mem [TABLE_DEPTH];
  logic [IDX_W-1:0] free_mem  [TABLE_DEPTH];

  // read data
  logic [31:0]      rd_addr, rd_stamp, rd_hits;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_older, rd_newer, free_rd;

  // request and table state
  logic [31:0]      src, now;
  logic [IDX_W-1:0] cur, slot, oldest, newest, clr_idx, scan_prev;
  logic [IDX_W:0]   scan_idx;
  logic             scan_pend;
  logic [OCC_W-1:0] occ, removed, occ_m1;
  logic [31:0]      total_hits, win_start;
  logic             started, allowed_r, found_r, overload_r;

  // working signals
  logic [IDX_W-1:0] rd_a, u_s;
  logic signed [33:0] now_s, win_s, age_rd, age_g, start_s;
  logic [31:0] hits_inc, g_inc, armed_sat;
  logic [CNT_W-1:0] occ_ext;

  // memory write ports
  logic addr_we, stamp_we, hits_we, valid_we, older_we, newer_we, free_we;
  logic [IDX_W-1:0] addr_wa, stamp_wa, hits_wa, valid_wa, older_wa, newer_wa, free_wa;
  logic [31:0] stamp_wd, hits_wd;
  logic valid_wd;
  logic [IDX_W-1:0] older_wd, newer_wd, free_wd;
  logic is_unlink, is_append;

  assign g_p1 = {1'b0, g_rate} + 17'd1;
  assign w_p1 = {1'b0, win_sec} + 17'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ps_rate   <= psqrl_pkg::RST_PER_SOURCE_RATE;
      win_sec   <= psqrl_pkg::RST_WINDOW_SECONDS;
      trk_limit <= psqrl_pkg::RST_TRACKED_LIMIT;
      quota     <= psqrl_pkg::RST_PRUNE_QUOTA;
      g_rate    <= psqrl_pkg::RST_GLOBAL_RATE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        psqrl_pkg::REG_PER_SOURCE_RATE: ps_rate   <= cfg_data;
        psqrl_pkg::REG_WINDOW_SECONDS:  win_sec   <= cfg_data;
        psqrl_pkg::REG_TRACKED_LIMIT:   trk_limit <= cfg_data[11:0];
        psqrl_pkg::REG_PRUNE_QUOTA:     quota     <= cfg_data[12:0];
        psqrl_pkg::REG_GLOBAL_RATE:     g_rate    <= cfg_data;
        default: ;
      endcase
    end
  end

  // rate limits, recomputed every cycle from the registers
  always_ff @(posedge clk) begin
    ps_lim    <= {16'd0, ps_rate} * {16'd0, win_sec};
    g_lim     <= {16'd0, g_rate} * {16'd0, win_sec};
    armed_raw <= {17'd0, g_p1} * {17'd0, w_p1};
  end

  assign armed_sat = (|armed_raw[33:32]) ? 32'hFFFF_FFFF : armed_raw[31:0];

  // ages as signed 34-bit values; an unstarted global window starts at -1
  assign now_s   = $signed({2'b00, now});
  assign win_s   = $signed({18'd0, win_sec});
  assign age_rd  = now_s - $signed({2'b00, rd_stamp});
  assign start_s = started ? $signed({2'b00, win_start}) : -34'sd1;
  assign age_g   = now_s - start_s;

  assign hits_inc = (&rd_hits) ? rd_hits : rd_hits + 32'd1;
  assign g_inc    = (&total_hits) ? total_hits : total_hits + 32'd1;
  assign occ_m1   = occ - OCC_W'(1);
  assign occ_ext  = CNT_W'(occ);
  assign u_s      = (op == psqrl_pkg::DP_DEL) ? cur : slot;

  always_comb begin
    unique case (op)
      psqrl_pkg::DP_READ_SLOT: rd_a = slot;
      psqrl_pkg::DP_SCAN_STEP: rd_a = scan_idx[IDX_W-1:0];
      default:                 rd_a = cur;
    endcase
  end

  assign is_unlink = (op == psqrl_pkg::DP_DEL) || (op == psqrl_pkg::DP_MOVE_UNLINK);
  assign is_append = (op == psqrl_pkg::DP_APPEND) || (op == psqrl_pkg::DP_INSERT);

  // write port selection: one write per memory per cycle
  always_comb begin
    addr_we  = (op == psqrl_pkg::DP_INSERT);
    addr_wa  = free_rd;
    stamp_we = (op == psqrl_pkg::DP_INSERT) || (op == psqrl_pkg::DP_MOVE_UNLINK);
    stamp_wa = (op == psqrl_pkg::DP_INSERT) ? free_rd : slot;
    stamp_wd = now;
    hits_we  = stamp_we || (op == psqrl_pkg::DP_HIT);
    hits_wa  = stamp_wa;
    hits_wd  = (op == psqrl_pkg::DP_HIT) ? hits_inc : 32'd1;
    valid_we = 1'b0;
    valid_wa = clr_idx;
    valid_wd = 1'b0;
    older_we = 1'b0;
    older_wa = rd_newer;
    older_wd = rd_older;
    newer_we = 1'b0;
    newer_wa = rd_older;
    newer_wd = rd_newer;
    free_we  = 1'b0;
    free_wa  = clr_idx;
    free_wd  = clr_idx;
    if (op == psqrl_pkg::DP_CLR_STEP) begin
      valid_we = 1'b1;
      free_we  = 1'b1;
    end
    if (is_unlink) begin
      valid_we = 1'b1;
      valid_wa = u_s;
      newer_we = (u_s != oldest);
      older_we = (u_s != newest);
      free_we  = 1'b1;
      free_wa  = occ_m1[IDX_W-1:0];
      free_wd  = u_s;
    end
    if (is_append) begin
      valid_we = 1'b1;
      valid_wa = (op == psqrl_pkg::DP_INSERT) ? free_rd : slot;
      valid_wd = 1'b1;
      older_we = 1'b1;
      older_wa = valid_wa;
      older_wd = newest;
      newer_we = (occ != '0);
      newer_wa = newest;
      newer_wd = valid_wa;
    end
  end

  always_ff @(posedge clk) begin
    if (addr_we)  addr_mem[addr_wa]   <= src;
    if (stamp_we) stamp_mem[stamp_wa] <= stamp_wd;
    if (hits_we)  hits_mem[hits_wa]   <= hits_wd;
    if (valid_we) valid_mem[valid_wa] <= valid_wd;
    if (older_we) older_mem[older_wa] <= older_wd;
    if (newer_we) newer_mem[newer_wa] <= newer_wd;
    if (free_we)  free_mem[free_wa]   <= free_wd;
    rd_addr  <= addr_mem[rd_a];
    rd_stamp <= stamp_mem[rd_a];
    rd_hits  <= hits_mem[rd_a];
    rd_valid <= valid_mem[rd_a];
    rd_older <= older_mem[rd_a];
    rd_newer <= newer_mem[rd_a];
    free_rd  <= free_mem[occ[IDX_W-1:0]];
  end

  // request registers
  always_ff @(posedge clk) begin
    if (op == psqrl_pkg::DP_LATCH) begin
      src <= source_addr;
      now <= now_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ        <= '0;
      oldest     <= '0;
      newest     <= '0;
      total_hits <= '0;
      win_start  <= '0;
      started    <= 1'b0;
      clr_idx    <= '0;
      scan_pend  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && (op != psqrl_pkg::DP_OUT_LOAD)) out_valid <= 1'b0;
      unique case (op) inside
        psqrl_pkg::DP_LATCH: begin
          cur        <= oldest;
          removed    <= '0;
          allowed_r  <= 1'b1;
          found_r    <= 1'b0;
          overload_r <= 1'b0;
        end
        psqrl_pkg::DP_CLR_STEP: clr_idx <= clr_idx + IDX_W'(1);
        psqrl_pkg::DP_SKIP:     cur <= rd_newer;
        psqrl_pkg::DP_DEL, psqrl_pkg::DP_MOVE_UNLINK: begin
          if (op == psqrl_pkg::DP_DEL) begin
            cur     <= rd_newer;
            removed <= removed + OCC_W'(1);
          end
          if (u_s == oldest) oldest <= rd_newer;
          if (u_s == newest) newest <= rd_older;
          occ <= occ_m1;
        end
        psqrl_pkg::DP_OVERLOAD: begin
          occ        <= '0;
          oldest     <= '0;
          newest     <= '0;
          total_hits <= armed_sat;
          win_start  <= now;
          started    <= 1'b1;
          overload_r <= 1'b1;
          clr_idx    <= '0;
        end
        psqrl_pkg::DP_SCAN_START: begin
          scan_idx  <= '0;
          scan_pend <= 1'b0;
        end
        psqrl_pkg::DP_SCAN_STEP: begin
          scan_prev <= scan_idx[IDX_W-1:0];
          scan_idx  <= scan_idx + (IDX_W+1)'(1);
          scan_pend <= 1'b1;
        end
        psqrl_pkg::DP_MARK_FOUND: begin
          slot    <= scan_prev;
          found_r <= 1'b1;
        end
        psqrl_pkg::DP_APPEND, psqrl_pkg::DP_INSERT: begin
          if (occ == '0) oldest <= valid_wa;
          newest <= valid_wa;
          occ    <= occ + OCC_W'(1);
        end
        psqrl_pkg::DP_HIT: begin
          if (hits_inc > ps_lim) allowed_r <= 1'b0;
        end
        psqrl_pkg::DP_GLOBAL: begin
          if (age_g > win_s) begin
            win_start  <= now;
            started    <= 1'b1;
            total_hits <= 32'd1;
          end else begin
            total_hits <= g_inc;
            if (g_inc > g_lim) allowed_r <= 1'b0;
          end
        end
        psqrl_pkg::DP_OUT_LOAD: begin
          out_valid      <= 1'b1;
          allowed        <= allowed_r;
          overload_reset <= overload_r;
          tracked_count  <= (occ_ext > CNT_W'(psqrl_pkg::COUNT_MAX)) ? psqrl_pkg::COUNT_MAX
                                                                      : occ_ext[12:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    st.occ_zero       = (occ == '0);
    st.over_limit     = occ_ext > CNT_W'(trk_limit);
    st.room           = occ < OCC_W'(TABLE_DEPTH);
    st.rd_valid       = rd_valid;
    st.is_src         = (rd_addr == src);
    st.is_last        = (cur == newest);
    st.young          = age_rd < win_s;
    st.stale          = age_rd > win_s;
    st.stop_after_del = (CNT_W'(removed) + CNT_W'(1) >= CNT_W'(quota)) &&
                        (occ_ext - CNT_W'(1) < CNT_W'(trk_limit));
    st.scan_hit       = scan_pend && rd_valid && (rd_addr == src);
    st.scan_end       = scan_pend && (scan_prev == IDX_W'(TABLE_DEPTH - 1));
    st.allowed        = allowed_r;
    st.found          = found_r;
    st.clr_last       = (clr_idx == IDX_W'(TABLE_DEPTH - 1));
    st.out_busy       = out_valid && !out_ready;
  end

endmodule

[rtl/per_source_query_rate_limiter.sv]
// ----------------------------------------------------------------------------
// per_source_query_rate_limiter
// Fixed-window query rate limiter per source address with a global limit.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_ready, source_addr, now_seconds) takes one
//   query at a time; in_ready is high only while the sequencer is idle.
//   Result channel (out_valid/out_ready) returns allowed, overload_reset and
//   tracked_count for every request, in order, from an output register.
//   A finished result may wait in that register while the next request is
//   taken; a stalled receiver only holds the block at the end of that next
//   request.
//   Per request: a latch, then the prune walk (a memory read and an
//   evaluation per entry visited), the overload check, the lookup scan
//   (none on an empty table; it stops at a match or runs through every
//   slot), a read and evaluation of a found entry plus a move to the
//   newest end when it is stale, then global check, insert, output load.
//   An overload clear sweeps the valid bits and free stack instead of the scan.
//   Reset: synchronous; afterwards a clearing pass over all entries runs
//   with in_ready low. The configuration port (cfg_write/cfg_index/cfg_data)
//   is taken at any time and should be written while the block is idle.
// ----------------------------------------------------------------------------
module per_source_query_rate_limiter #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] source_addr,
  input  logic [31:0] now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        allowed,
  output logic        overload_reset,
  output logic [12:0] tracked_count
);

  psqrl_pkg::dp_op_t     op;
  psqrl_pkg::dp_status_t st;

  // sequencer: one request at a time
  psqrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .op       (op)
  );

  // table memories, age list, counters and output register
  psqrl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .source_addr    (source_addr),
    .now_seconds    (now_seconds),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .allowed        (allowed),
    .overload_reset (overload_reset),
    .tracked_count  (tracked_count),
    .st             (st)
  );

  // only one request in flight
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in flight");

  // an overload clear leaves at most the one newly inserted source
  a_overload_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overload_reset) |-> (tracked_count <= 13'd1))
    else $error("table not emptied by overload clear");

  // lookup hit only comes from a pending scan read
  a_scan_hit: assert property (@(posedge clk) disable iff (rst)
    st.scan_hit |-> !st.scan_end || st.rd_valid)
    else $error("scan hit without a valid entry");

endmodule
